/* design/bshr_pkg.sv */
// Shared types, codes and constants for the backend selector hash ring.
package bshr_pkg;

   localparam int unsigned DEF_MAX_BACKENDS = 16;
   localparam int unsigned DEF_RING_DEPTH   = 4096;
   localparam int unsigned DEF_WEIGHT_DEPTH = 1024;

   localparam int unsigned HASH_W    = 32;
   localparam int unsigned ADDR_W    = 12;
   localparam int unsigned BACKEND_W = 4;
   localparam int unsigned RING_W    = HASH_W + BACKEND_W;

   // Register field widths; the counts that follow from them bound the datapath.
   localparam int unsigned STRAT_W = 2;
   localparam int unsigned BCNT_W  = 5;
   localparam int unsigned RCNT_W  = 13;
   localparam int unsigned WCNT_W  = 11;
   localparam int unsigned DIV_W   = WCNT_W;

   localparam int unsigned CSR_AW = 4;
   localparam int unsigned CSR_DW = 32;

   // Register indexes (byte address / 4)
   localparam logic [1:0] REG_STRATEGY      = 2'd0;
   localparam logic [1:0] REG_BACKEND_COUNT = 2'd1;
   localparam logic [1:0] REG_RING_ENTRIES  = 2'd2;
   localparam logic [1:0] REG_WEIGHT_SLOTS  = 2'd3;

   localparam logic [1:0] STRAT_PLAIN    = 2'd0;
   localparam logic [1:0] STRAT_WEIGHTED = 2'd1;
   localparam logic [1:0] STRAT_RING     = 2'd2;

   localparam logic [1:0] FUNC_LOOKUP   = 2'd0;
   localparam logic [1:0] FUNC_RING_WR  = 2'd1;
   localparam logic [1:0] FUNC_SLOT_WR  = 2'd2;

   localparam logic [1:0] STAT_LOOKUP = 2'd0;
   localparam logic [1:0] STAT_WRITE  = 2'd1;
   localparam logic [1:0] STAT_RANGE  = 2'd2;

   typedef struct packed {
      logic [STRAT_W-1:0] strategy;
      logic [BCNT_W-1:0]  backend_count;
      logic [RCNT_W-1:0]  ring_entries;
      logic [WCNT_W-1:0]  weight_slots;
   } cfg_type;

   typedef struct packed {
      logic                 en;
      logic [ADDR_W-1:0]    addr;
      logic [HASH_W-1:0]    point;
      logic [BACKEND_W-1:0] backend;
   } ring_wr_type;

   typedef struct packed {
      logic              start;
      logic [RCNT_W-1:0] count;
      logic [HASH_W-1:0] hash;
   } ring_req_type;

   typedef struct packed {
      logic                 done;
      logic [BACKEND_W-1:0] backend;
   } ring_rsp_type;

   typedef struct packed {
      logic              start;
      logic [HASH_W-1:0] dividend;
      logic [DIV_W-1:0]  divisor;
   } rem_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] remainder;
   } rem_rsp_type;

endpackage

/* design/bshr_csr.sv */
// Configuration register file behind the APB-style port.
module bshr_csr
   import bshr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready,
   output cfg_type           cfg
);

   cfg_type    cfg_ff, cfg_in;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[3:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_STRATEGY:      cfg_in.strategy      = csr_pwdata[STRAT_W-1:0];
            REG_BACKEND_COUNT: cfg_in.backend_count = csr_pwdata[BCNT_W-1:0];
            REG_RING_ENTRIES:  cfg_in.ring_entries  = csr_pwdata[RCNT_W-1:0];
            REG_WEIGHT_SLOTS:  cfg_in.weight_slots  = csr_pwdata[WCNT_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.strategy      <= STRAT_RING;
         cfg_ff.backend_count <= BCNT_W'(1);
         cfg_ff.ring_entries  <= RCNT_W'(1);
         cfg_ff.weight_slots  <= WCNT_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_STRATEGY:      csr_prdata = CSR_DW'(cfg_ff.strategy);
         REG_BACKEND_COUNT: csr_prdata = CSR_DW'(cfg_ff.backend_count);
         REG_RING_ENTRIES:  csr_prdata = CSR_DW'(cfg_ff.ring_entries);
         REG_WEIGHT_SLOTS:  csr_prdata = CSR_DW'(cfg_ff.weight_slots);
         default:           csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

/* design/bshr_rem.sv */
// Iterative restoring remainder: one dividend bit per cycle over all 32 dividend bits.
module bshr_rem
   import bshr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  rem_req_type req,
   output rem_rsp_type rsp
);

   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [4:0]        cnt_ff, cnt_in;
   logic [HASH_W-1:0] dvd_ff, dvd_in;
   logic [DIV_W-1:0]  div_ff, div_in;
   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic [DIV_W:0]    shifted;
   logic [DIV_W:0]    diff;

   assign shifted = {rem_ff, dvd_ff[HASH_W-1]};
   assign diff    = shifted - {1'b0, div_ff};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      if (req.start) begin
         run_in = 1'b1;
         cnt_in = '0;
         dvd_in = req.dividend;
         div_in = req.divisor;
         rem_in = '0;
      end else if (run_ff) begin
         dvd_in = {dvd_ff[HASH_W-2:0], 1'b0};
         // remainder stays below the divisor, so one compare-subtract suffices
         rem_in = (shifted >= {1'b0, div_ff}) ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.remainder = rem_ff;

endmodule

/* design/bshr_ring.sv */
// Ring point/backend memory and the lower-bound search that walks it.
module bshr_ring
   import bshr_pkg::*;
#(
   parameter int unsigned RING_DEPTH = DEF_RING_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  ring_wr_type  wr,
   input  ring_req_type req,
   output ring_rsp_type rsp
);

   localparam int unsigned AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

   typedef enum logic [2:0] {
      RS_IDLE  = 3'b001,
      RS_PROBE = 3'b010,
      RS_FETCH = 3'b100
   } ring_state_type;

   ring_state_type    state_ff, state_in;
   logic [RCNT_W-1:0] lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in, n_ff, n_in;
   logic [HASH_W-1:0] hash_ff, hash_in;
   logic [RING_W-1:0] rd_data_ff;
   logic [RING_W-1:0] ring_mem [RING_DEPTH];

   logic              point_lt;
   logic [RCNT_W-1:0] lo_nx, hi_nx, mid_nx, fin_idx, rd_idx;
   logic [RCNT_W:0]   sum;
   logic              rd_en;
   logic [31:0]       rd_wide, wr_wide;
   logic [AW-1:0]     rd_addr, wr_addr;

   assign point_lt = rd_data_ff[RING_W-1:BACKEND_W] < hash_ff;
   assign lo_nx    = point_lt ? mid_ff + RCNT_W'(1) : lo_ff;
   assign hi_nx    = point_lt ? hi_ff : mid_ff;
   assign sum      = {1'b0, lo_nx} + {1'b0, hi_nx};
   assign mid_nx   = sum[RCNT_W:1];
   // nothing at or above the hash: wrap to the first entry
   assign fin_idx  = (lo_nx >= n_ff) ? '0 : lo_nx;

   always_comb begin
      state_in = state_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      mid_in   = mid_ff;
      n_in     = n_ff;
      hash_in  = hash_ff;
      rd_en    = 1'b0;
      rd_idx   = mid_nx;
      case (state_ff)
         RS_IDLE: begin
            if (req.start) begin
               n_in     = req.count;
               hash_in  = req.hash;
               lo_in    = '0;
               hi_in    = req.count;
               mid_in   = req.count >> 1;
               rd_en    = 1'b1;
               rd_idx   = req.count >> 1;
               state_in = RS_PROBE;
            end
         end
         RS_PROBE: begin
            lo_in = lo_nx;
            hi_in = hi_nx;
            rd_en = 1'b1;
            if (lo_nx < hi_nx) begin
               mid_in = mid_nx;
               rd_idx = mid_nx;
            end else begin
               rd_idx   = fin_idx;
               state_in = RS_FETCH;
            end
         end
         RS_FETCH: state_in = RS_IDLE;
         default:  state_in = RS_IDLE;
      endcase
   end

   assign rd_wide = 32'(rd_idx);
   assign rd_addr = rd_wide[AW-1:0];
   assign wr_wide = 32'(wr.addr);
   assign wr_addr = wr_wide[AW-1:0];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         ring_mem[wr_addr] <= {wr.point, wr.backend};
      end
      if (rd_en) begin
         rd_data_ff <= ring_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= RS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      mid_ff  <= mid_in;
      n_ff    <= n_in;
      hash_ff <= hash_in;
   end

   assign rsp.done    = (state_ff == RS_FETCH);
   assign rsp.backend = rd_data_ff[BACKEND_W-1:0];

endmodule

/* design/backend_selector_hash_ring.sv */
// Top level: request sequencer, weight slot memory and result register.
//
//   channel | dir | handshake             | payload
//   req     | in  | req_tvalid/req_tready | tdata key_hash, entry_address, entry_point,
//           |     |                       | entry_backend; tuser func
//   rsp     | out | rsp_tvalid/rsp_tready | tdata backend_index; tuser status
//   csr     | in  | csr_psel/csr_penable  | APB-style, 4 registers at 0x0..0xC
//
// One item at a time. Table writes and bad items go straight to the done state.
// Plain lookup runs the 32-step remainder unit; weighted adds one slot memory
// read after it. Ring lookup: probes <= ceil(log2(n+1)), one ring memory read per
// probe. No clearing pass after reset.
// A finished result waits in the output register; the next item is accepted
// meanwhile and its result is held until the register frees.
module backend_selector_hash_ring
   import bshr_pkg::*;
#(
   parameter int unsigned MAX_BACKENDS = DEF_MAX_BACKENDS,
   parameter int unsigned RING_DEPTH   = DEF_RING_DEPTH,
   parameter int unsigned WEIGHT_DEPTH = DEF_WEIGHT_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // [31:0] key_hash, [43:32] entry_address, [75:44] entry_point, [79:76] entry_backend
   input  logic [79:0]       req_tdata,
   // [1:0] func
   input  logic [1:0]        req_tuser,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // [3:0] backend_index, [7:4] zero
   output logic [7:0]        rsp_tdata,
   // [1:0] status
   output logic [1:0]        rsp_tuser,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   localparam int unsigned WAW = (WEIGHT_DEPTH > 1) ? $clog2(WEIGHT_DEPTH) : 1;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_DIV  = 5'b00010,
      ST_SLOT = 5'b00100,
      ST_RING = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   state_type            state_ff, state_in;
   logic [BACKEND_W-1:0] res_backend_ff, res_backend_in;
   logic [1:0]           res_status_ff, res_status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [BACKEND_W-1:0] rsp_backend_ff, rsp_backend_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;
   logic [BACKEND_W-1:0] slot_rd_ff;
   logic [BACKEND_W-1:0] slot_mem [WEIGHT_DEPTH];

   cfg_type              cfg;
   ring_wr_type          ring_wr;
   ring_req_type         ring_req;
   ring_rsp_type         ring_rsp;
   rem_req_type          rem_req;
   rem_rsp_type          rem_rsp;

   logic                 accept, out_free;
   logic [1:0]           func;
   logic [HASH_W-1:0]    key_hash, entry_point;
   logic [ADDR_W-1:0]    entry_address;
   logic [BACKEND_W-1:0] entry_backend;
   logic                 ring_in_range, slot_in_range;
   logic                 slot_wr_en, slot_rd_en;
   logic [31:0]          addr_wide, rem_wide;
   logic [WAW-1:0]       slot_wr_addr, slot_rd_addr;
   logic [BCNT_W-1:0]    bcnt_eff;
   logic [RCNT_W-1:0]    rcnt_eff;
   logic [WCNT_W-1:0]    wcnt_eff;

   bshr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign func          = req_tuser;
   assign key_hash      = req_tdata[31:0];
   assign entry_address = req_tdata[43:32];
   assign entry_point   = req_tdata[75:44];
   assign entry_backend = req_tdata[79:76];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign out_free   = ~rsp_valid_ff | rsp_tready;

   // zero counts act as one, oversized counts as the table depth (backends: MAX_BACKENDS)
   always_comb begin
      if (cfg.backend_count == '0) begin
         bcnt_eff = BCNT_W'(1);
      end else if (32'(cfg.backend_count) > MAX_BACKENDS) begin
         bcnt_eff = BCNT_W'(MAX_BACKENDS);
      end else begin
         bcnt_eff = cfg.backend_count;
      end
      if (cfg.ring_entries == '0) begin
         rcnt_eff = RCNT_W'(1);
      end else if (32'(cfg.ring_entries) > RING_DEPTH) begin
         rcnt_eff = RCNT_W'(RING_DEPTH);
      end else begin
         rcnt_eff = cfg.ring_entries;
      end
      if (cfg.weight_slots == '0) begin
         wcnt_eff = WCNT_W'(1);
      end else if (32'(cfg.weight_slots) > WEIGHT_DEPTH) begin
         wcnt_eff = WCNT_W'(WEIGHT_DEPTH);
      end else begin
         wcnt_eff = cfg.weight_slots;
      end
   end

   assign addr_wide     = 32'(entry_address);
   assign ring_in_range = addr_wide < RING_DEPTH;
   assign slot_in_range = addr_wide < WEIGHT_DEPTH;
   assign slot_wr_addr  = addr_wide[WAW-1:0];
   assign rem_wide      = 32'(rem_rsp.remainder);
   assign slot_rd_addr  = rem_wide[WAW-1:0];

   assign ring_wr.en      = accept & (func == FUNC_RING_WR) & ring_in_range;
   assign ring_wr.addr    = entry_address;
   assign ring_wr.point   = entry_point;
   assign ring_wr.backend = entry_backend;

   assign ring_req.start = accept & (func == FUNC_LOOKUP) & (cfg.strategy == STRAT_RING);
   assign ring_req.count = rcnt_eff;
   assign ring_req.hash  = key_hash;

   assign rem_req.start    = accept & (func == FUNC_LOOKUP) & (cfg.strategy != STRAT_RING);
   assign rem_req.dividend = key_hash;
   assign rem_req.divisor  = (cfg.strategy == STRAT_WEIGHTED) ? wcnt_eff
                                                               : DIV_W'(bcnt_eff);

   bshr_ring #(
      .RING_DEPTH (RING_DEPTH)
   ) u_ring (
      .clock (clock),
      .reset (reset),
      .wr    (ring_wr),
      .req   (ring_req),
      .rsp   (ring_rsp)
   );

   bshr_rem u_rem (
      .clock (clock),
      .reset (reset),
      .req   (rem_req),
      .rsp   (rem_rsp)
   );

   assign slot_wr_en = accept & (func == FUNC_SLOT_WR) & slot_in_range;
   assign slot_rd_en = (state_ff == ST_DIV) & rem_rsp.done;

   always_ff @(posedge clock) begin
      if (slot_wr_en) begin
         slot_mem[slot_wr_addr] <= entry_backend;
      end
      if (slot_rd_en) begin
         slot_rd_ff <= slot_mem[slot_rd_addr];
      end
   end

   always_comb begin
      state_in       = state_ff;
      res_backend_in = res_backend_ff;
      res_status_in  = res_status_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_tready;
      rsp_backend_in = rsp_backend_ff;
      rsp_status_in  = rsp_status_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_backend_in = '0;
               res_status_in  = STAT_RANGE;
               state_in       = ST_DONE;
               case (func)
                  FUNC_LOOKUP: begin
                     res_status_in = STAT_LOOKUP;
                     state_in      = (cfg.strategy == STRAT_RING) ? ST_RING : ST_DIV;
                  end
                  FUNC_RING_WR: begin
                     if (ring_in_range) begin
                        res_status_in = STAT_WRITE;
                     end
                  end
                  FUNC_SLOT_WR: begin
                     if (slot_in_range) begin
                        res_status_in = STAT_WRITE;
                     end
                  end
                  default: res_status_in = STAT_RANGE;
               endcase
            end
         end
         ST_DIV: begin
            if (rem_rsp.done) begin
               if (cfg.strategy == STRAT_WEIGHTED) begin
                  state_in = ST_SLOT;
               end else begin
                  res_backend_in = rem_rsp.remainder[BACKEND_W-1:0];
                  state_in       = ST_DONE;
               end
            end
         end
         ST_SLOT: begin
            res_backend_in = slot_rd_ff;
            state_in       = ST_DONE;
         end
         ST_RING: begin
            if (ring_rsp.done) begin
               res_backend_in = ring_rsp.backend;
               state_in       = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_backend_in = res_backend_ff;
               rsp_status_in  = res_status_ff;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_backend_ff <= res_backend_in;
      res_status_ff  <= res_status_in;
      rsp_backend_ff <= rsp_backend_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_backend_ff};
   assign rsp_tuser  = rsp_status_ff;

   // a transfer in always leaves the idle state on the next cycle
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != ST_IDLE))
      else $error("accepted transfer did not start work");

   // the ring search and the remainder unit never finish together
   a_one_engine: assert property (@(posedge clock) disable iff (reset)
      !(ring_rsp.done && rem_rsp.done))
      else $error("ring search and remainder unit finished together");

   // results other than lookups carry backend zero
   a_write_backend_zero: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DONE) && (res_status_ff != STAT_LOOKUP)) |-> (res_backend_ff == '0))
      else $error("non-lookup result with nonzero backend");

   // the output register is loaded only from the done state
   a_load_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result register loaded outside done state");

endmodule
